### design/otb_pkg.sv
// Shared types, register map and operation codes for the one-shot basic timer.
package otb_pkg;

  // Counter width and bus data width.
  localparam int CntW  = 16;
  localparam int DataW = 16;
  localparam int OpW   = 2;
  localparam int IdxW  = 3;

  // Request kinds.
  localparam logic [OpW-1:0] OP_TICK  = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE = 2'd1;
  localparam logic [OpW-1:0] OP_READ  = 2'd2;

  // Register map.
  localparam logic [IdxW-1:0] REG_CTRL    = 3'd0;
  localparam logic [IdxW-1:0] REG_PRESC   = 3'd1;
  localparam logic [IdxW-1:0] REG_RELOAD  = 3'd2;
  localparam logic [IdxW-1:0] REG_EVGEN   = 3'd3;
  localparam logic [IdxW-1:0] REG_STATUS  = 3'd4;
  localparam logic [IdxW-1:0] REG_IRQ_EN  = 3'd5;
  localparam logic [IdxW-1:0] REG_COUNTER = 3'd6;

  // Bit positions inside control-type registers.
  localparam int CtrlEnBit = 0;
  localparam int CtrlOpmBit = 1;

  typedef logic [CntW-1:0] cnt_t;

  // One request as held in the input register.
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
  } req_t;

  // One result as held in the output register.
  typedef struct packed {
    logic             update_pulse;
    logic             irq_pending;
    logic [DataW-1:0] read_data;
  } res_t;

  // Timer status bits seen by the top level.
  typedef struct packed {
    logic enable;
    logic one_pulse;
    logic update_flag;
    logic irq_en;
  } sts_t;

endpackage

### design/otb_core.sv
// Timer state registers and the single-pass update logic for one request.
module otb_core
  import otb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t req,
  output res_t res,
  output sts_t sts
);

  logic enable, enable_next;
  logic one_pulse, one_pulse_next;
  cnt_t presc_pre, presc_pre_next;
  cnt_t presc_act, presc_act_next;
  cnt_t presc_cnt, presc_cnt_next;
  cnt_t reload, reload_next;
  cnt_t count, count_next;
  logic update_flag, update_flag_next;
  logic irq_en, irq_en_next;
  logic upd;
  logic [DataW-1:0] rd;

  // Next state and result for the request in the input register.
  always_comb begin
    enable_next      = enable;
    one_pulse_next   = one_pulse;
    presc_pre_next   = presc_pre;
    presc_act_next   = presc_act;
    presc_cnt_next   = presc_cnt;
    reload_next      = reload;
    count_next       = count;
    update_flag_next = update_flag;
    irq_en_next      = irq_en;
    upd              = 1'b0;
    rd               = '0;
    case (req.op)
      OP_TICK: begin
        if (enable) begin
          if (presc_cnt < presc_act) begin
            presc_cnt_next = presc_cnt + cnt_t'(1);
          end else begin
            presc_cnt_next = '0;
            if (count == reload) begin
              count_next = '0;
              upd        = 1'b1;
            end else begin
              count_next = count + cnt_t'(1);
            end
          end
        end
      end
      OP_WRITE: begin
        case (req.idx)
          REG_CTRL: begin
            enable_next    = req.data[CtrlEnBit];
            one_pulse_next = req.data[CtrlOpmBit];
          end
          REG_PRESC:  presc_pre_next = cnt_t'(req.data);
          REG_RELOAD: reload_next = cnt_t'(req.data);
          REG_EVGEN: begin
            if (req.data[0]) begin
              count_next = '0;
              upd        = 1'b1;
            end
          end
          REG_STATUS: begin
            if (!req.data[0]) update_flag_next = 1'b0;
          end
          REG_IRQ_EN: irq_en_next = req.data[0];
          default: ;
        endcase
      end
      OP_READ: begin
        case (req.idx)
          REG_CTRL:    rd = DataW'({one_pulse, enable});
          REG_PRESC:   rd = DataW'(presc_pre);
          REG_RELOAD:  rd = DataW'(reload);
          REG_STATUS:  rd = DataW'(update_flag);
          REG_IRQ_EN:  rd = DataW'(irq_en);
          REG_COUNTER: rd = DataW'(count);
          default:     rd = '0;
        endcase
      end
      default: ;
    endcase
    // An update event, counted or forced, restarts the prescaler.
    if (upd) begin
      presc_cnt_next   = '0;
      presc_act_next   = presc_pre;
      update_flag_next = 1'b1;
      if (one_pulse) enable_next = 1'b0;
    end
  end

  // Interrupt and update fields reflect the state after the request; read data shows the state before it.
  always_comb begin
    res.read_data    = rd;
    res.irq_pending  = update_flag_next & irq_en_next;
    res.update_pulse = upd;
  end

  // State registers advance once per processed request.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      one_pulse   <= 1'b0;
      presc_pre   <= '0;
      presc_act   <= '0;
      presc_cnt   <= '0;
      reload      <= '1;
      count       <= '0;
      update_flag <= 1'b0;
      irq_en      <= 1'b0;
    end else if (fire) begin
      enable      <= enable_next;
      one_pulse   <= one_pulse_next;
      presc_pre   <= presc_pre_next;
      presc_act   <= presc_act_next;
      presc_cnt   <= presc_cnt_next;
      reload      <= reload_next;
      count       <= count_next;
      update_flag <= update_flag_next;
      irq_en      <= irq_en_next;
    end
  end

  assign sts = '{enable: enable, one_pulse: one_pulse,
                 update_flag: update_flag, irq_en: irq_en};

endmodule

### design/one_shot_basic_timer.sv
// One-shot basic timer: request stream in, one result per request out.
// The block takes one request per clock cycle unless its output is stalled
// (tick, register write or register read) and returns one result for each, in
// order: the request is held in an input register, the timer state and
// the result are computed in a single pass of logic, and the result waits in
// an output register. A stalled output holds the result while one more
// request can still be taken into the input register.
module one_shot_basic_timer
  import otb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] write_data
  input  logic [4:0]  s_tuser,   // [1:0] op, [4:2] reg_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [15:0] read_data, [16] irq_pending,
                                 // [17] update_pulse, [23:18] zero
);

  logic in_valid;
  req_t in_req;
  logic out_valid;
  res_t out_res;
  res_t core_res;
  sts_t sts;
  logic advance;

  // The request moves on when the output register is free or being drained.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req <= '{op: s_tuser[1:0], idx: s_tuser[4:2], data: s_tdata};
    end
  end

  otb_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (in_req),
    .res  (core_res),
    .sts  (sts)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_res};

  // The input side stalls only behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a blocked output");

  // A new result carries the interrupt state left by its request.
  a_irq_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_res.irq_pending == (sts.update_flag && sts.irq_en)))
    else $error("irq_pending does not match timer state");

  // An update sets the flag.
  a_update_flag: assert property (@(posedge clk) disable iff (rst)
    (advance && core_res.update_pulse) |=> sts.update_flag)
    else $error("update event did not set the flag");

  // In one-pulse mode an update stops the timer.
  a_one_pulse_stop: assert property (@(posedge clk) disable iff (rst)
    (advance && core_res.update_pulse && sts.one_pulse) |=> !sts.enable)
    else $error("one-pulse update left the timer enabled");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the one-shot basic timer request stream.
`timescale 1ns / 1ps

module tb_top;
  import otb_pkg::*;

  // Codes that the package leaves unnamed: the spare request kind and register slot.
  localparam logic [OpW-1:0]  OP_NONE  = 2'd3;
  localparam logic [IdxW-1:0] REG_NONE = 3'd7;

  localparam int ResetCycles   = 12;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 8;
  localparam int PhaseRequests = 275;

  // One row of the directed table; want is used only where fixed is set.
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
    logic             fixed;
    res_t             want;
  } dir_row_t;

  localparam int NumRows = 27;
  localparam dir_row_t DirRows [NumRows] = '{
    // Values straight after reset.
    '{OP_READ,  REG_RELOAD,  16'h0000, 1'b1, '{1'b0, 1'b0, 16'hFFFF}},
    '{OP_READ,  REG_CTRL,    16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000}},
    '{OP_READ,  REG_COUNTER, 16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000}},
    '{OP_TICK,  REG_CTRL,    16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000}},
    // Reload of zero: the first enabled tick is an update.
    '{OP_WRITE, REG_RELOAD,  16'h0000, 1'b0, '0},
    '{OP_WRITE, REG_IRQ_EN,  16'h0001, 1'b0, '0},
    '{OP_WRITE, REG_CTRL,    16'h0001, 1'b0, '0},
    '{OP_TICK,  REG_CTRL,    16'h0000, 1'b0, '0},
    '{OP_READ,  REG_STATUS,  16'h0000, 1'b0, '0},
    // Writing one to the flag keeps it, writing zero clears it.
    '{OP_WRITE, REG_STATUS,  16'h0001, 1'b0, '0},
    '{OP_WRITE, REG_STATUS,  16'h0000, 1'b0, '0},
    // Forced update latches the largest prescaler.
    '{OP_WRITE, REG_PRESC,   16'hFFFF, 1'b0, '0},
    '{OP_WRITE, REG_EVGEN,   16'hFFFF, 1'b0, '0},
    '{OP_WRITE, REG_PRESC,   16'h0001, 1'b0, '0},
    '{OP_WRITE, REG_RELOAD,  16'hFFFF, 1'b0, '0},
    '{OP_TICK,  REG_CTRL,    16'h0000, 1'b0, '0},
    '{OP_TICK,  REG_CTRL,    16'h0000, 1'b0, '0},
    // The counter is read-only, and the spare slot holds nothing.
    '{OP_WRITE, REG_COUNTER, 16'hFFFF, 1'b0, '0},
    '{OP_READ,  REG_COUNTER, 16'h0000, 1'b0, '0},
    '{OP_WRITE, REG_NONE,    16'hFFFF, 1'b0, '0},
    '{OP_READ,  REG_NONE,    16'h0000, 1'b0, '0},
    '{OP_NONE,  REG_NONE,    16'hFFFF, 1'b0, '0},
    '{OP_READ,  REG_EVGEN,   16'h0000, 1'b0, '0},
    // One-pulse mode: a forced update drops the enable.
    '{OP_WRITE, REG_CTRL,    16'h0003, 1'b0, '0},
    '{OP_WRITE, REG_EVGEN,   16'h0000, 1'b0, '0},
    '{OP_WRITE, REG_EVGEN,   16'h0001, 1'b0, '0},
    '{OP_READ,  REG_CTRL,    16'h0000, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] write_data
  logic [4:0]  s_tuser = '0;   // [1:0] op, [4:2] reg_index
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [15:0] read_data, [16] irq_pending,
                               // [17] update_pulse, [23:18] zero

  // Timer state as predicted from the accepted requests.
  logic t_enable    = 1'b0;
  logic t_one_pulse = 1'b0;
  cnt_t t_presc_pre = '0;
  cnt_t t_presc_act = '0;
  cnt_t t_presc_cnt = '0;
  cnt_t t_reload    = '1;
  cnt_t t_count     = '0;
  logic t_flag      = 1'b0;
  logic t_irq_en    = 1'b0;

  res_t expected_results [$];
  int   idle_pct     = 0;
  int   stall_pct    = 0;
  int   error_count  = 0;
  int   quiet_cycles = 0;

  one_shot_basic_timer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the predicted timer by one request and return its result.
  task automatic predict_timer(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                               input logic [DataW-1:0] data, output res_t res);
    logic fire;
    fire = 1'b0;
    res  = '0;
    case (op)
      OP_TICK: begin
        if (t_enable) begin
          if (t_presc_cnt < t_presc_act) begin
            t_presc_cnt = t_presc_cnt + cnt_t'(1);
          end else if (t_count == t_reload) begin
            t_count = '0;
            fire    = 1'b1;
          end else begin
            t_presc_cnt = '0;
            t_count     = t_count + cnt_t'(1);
          end
        end
      end
      OP_WRITE: begin
        case (idx)
          REG_CTRL: begin
            t_enable    = data[CtrlEnBit];
            t_one_pulse = data[CtrlOpmBit];
          end
          REG_PRESC:  t_presc_pre = data;
          REG_RELOAD: t_reload = data;
          REG_EVGEN: begin
            if (data[0]) begin
              t_count = '0;
              fire    = 1'b1;
            end
          end
          REG_STATUS: begin
            if (!data[0]) t_flag = 1'b0;
          end
          REG_IRQ_EN: t_irq_en = data[0];
          default: ;
        endcase
      end
      OP_READ: begin
        case (idx)
          REG_CTRL: begin
            res.read_data[CtrlEnBit]  = t_enable;
            res.read_data[CtrlOpmBit] = t_one_pulse;
          end
          REG_PRESC:   res.read_data = t_presc_pre;
          REG_RELOAD:  res.read_data = t_reload;
          REG_STATUS:  res.read_data[0] = t_flag;
          REG_IRQ_EN:  res.read_data[0] = t_irq_en;
          REG_COUNTER: res.read_data = t_count;
          default: ;
        endcase
      end
      default: ;
    endcase
    // Counted and forced updates share the same side effects.
    if (fire) begin
      t_presc_cnt = '0;
      t_presc_act = t_presc_pre;
      t_flag      = 1'b1;
      if (t_one_pulse) t_enable = 1'b0;
    end
    res.irq_pending  = t_flag & t_irq_en;
    res.update_pulse = fire;
  endtask

  // Offer one request from a falling edge and hold it until it is taken.
  task automatic send_request(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                              input logic [DataW-1:0] data, input logic fixed,
                              input res_t want);
    res_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = 16'($urandom);
      s_tuser  = 5'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = data;
    s_tuser  = {idx, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_timer(op, idx, data, predicted);
    expected_results.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  // Random request, weighted toward ticks and short timer periods.
  task automatic make_request(output logic [OpW-1:0] op, output logic [IdxW-1:0] idx,
                              output logic [DataW-1:0] data);
    int pick;
    pick = $urandom_range(99);
    if (pick < 58)      op = OP_TICK;
    else if (pick < 82) op = OP_WRITE;
    else if (pick < 97) op = OP_READ;
    else                op = OP_NONE;
    idx  = 3'($urandom_range(7));
    data = 16'($urandom_range(65535));
    if (op == OP_WRITE) begin
      case (idx)
        // Mostly keep the timer running so the counting logic is exercised.
        REG_CTRL: begin
          if ($urandom_range(9) != 0) begin
            data = {14'd0, 1'($urandom_range(1)), 1'($urandom_range(99) < 80)};
          end
        end
        REG_PRESC: begin
          if ($urandom_range(99) < 85) data = 16'($urandom_range(3));
        end
        REG_RELOAD: begin
          if ($urandom_range(99) < 85) data = 16'($urandom_range(12));
        end
        default: ;
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Receiver: random back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= stall_pct);
  end

  // Compare each result with the oldest expectation; watch for a hung stream.
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[17:0];
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", 32'(got), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.read_data != want.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
          if (got.irq_pending != want.irq_pending)
            report_mismatch("irq_pending", 32'(got.irq_pending), 32'(want.irq_pending));
          if (got.update_pulse != want.update_pulse)
            report_mismatch("update_pulse", 32'(got.update_pulse),
                            32'(want.update_pulse));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  // Stimulus: directed table, random phases, then a reload lowered below the count.
  initial begin : stimulus
    logic [OpW-1:0]   op;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < NumRows; r++) begin
      send_request(DirRows[r].op, DirRows[r].idx, DirRows[r].data,
                   DirRows[r].fixed, DirRows[r].want);
    end

    // Idling phases: none, sender only, receiver only, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      repeat (PhaseRequests) begin
        make_request(op, idx, data);
        send_request(op, idx, data, 1'b0, '0);
      end
    end

    // Counter above reload: it keeps counting past the new reload value
    // without an update.
    idle_pct  = 0;
    stall_pct = 0;
    send_request(OP_WRITE, REG_CTRL,   16'h0001, 1'b0, '0);
    send_request(OP_WRITE, REG_PRESC,  16'h0000, 1'b0, '0);
    send_request(OP_WRITE, REG_EVGEN,  16'h0001, 1'b0, '0);
    send_request(OP_WRITE, REG_RELOAD, 16'hFFFF, 1'b0, '0);
    repeat (20) send_request(OP_TICK, REG_CTRL, 16'h0000, 1'b0, '0);
    send_request(OP_WRITE, REG_RELOAD, 16'h0005, 1'b0, '0);
    repeat (20) send_request(OP_TICK, REG_CTRL, 16'h0000, 1'b0, '0);
    send_request(OP_READ, REG_COUNTER, 16'h0000, 1'b0, '0);
    s_tvalid = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### sim.f
design/otb_pkg.sv
design/otb_core.sv
design/one_shot_basic_timer.sv
tb/tb_top.sv
